@@ design/slcg_pkg.sv @@
// shared constants for the shuffled minimal-standard random generator
package slcg_pkg;

    localparam int DATA_W = 31;
    localparam int DEF_TABLE_SIZE = 32;
    localparam int WARMUP_EXTRA = 7;
    localparam logic [14:0] LCG_MULT = 15'd16807;
    localparam logic [31:0] LCG_MOD = 32'h7FFF_FFFF;

endpackage

@@ design/shuffled_lcg_random_generator.sv @@
// top level of the shuffled minimal-standard random generator
// Each request on the slave stream yields one deviate in 1 .. 2^31-2 on the master stream;
// divide by 2^31-1 for a fraction. A request with reseed set, and the first request after
// reset, starts the generator from the seed register (0 and 2^31-1 both act as 1) and runs
// TABLE_SIZE+8 generator steps that fill the shuffle table before drawing. Every generator step goes
// through the 31x15 multiplier, whose product is registered, and then a modulo fold. A plain
// draw is one table read followed by a write of the same entry. When (2^31-2)/TABLE_SIZE+1
// is a power of two (any power-of-two TABLE_SIZE, the default 32 included) the table index
// is a shift; otherwise it needs a reciprocal multiply and a correction. A finished result
// sits in an output register; the next request is taken while it waits. The seed must be
// written only while idle; the block itself does not enforce it.
module shuffled_lcg_random_generator #(
    parameter int TABLE_SIZE = slcg_pkg::DEF_TABLE_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] reseed, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] random_value, [31] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W = $clog2(TABLE_SIZE + slcg_pkg::WARMUP_EXTRA + 1);
    localparam int DW = slcg_pkg::DATA_W;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SEED_MUL = 5'b00010,
        S_SEED_RED = 5'b00100,
        S_IDX_WAIT = 5'b01000,
        S_DRAW     = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [DW-1:0]    r_seed;
    logic             r_seeded;
    logic [DW-1:0]    r_lcg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovalid;
    logic [DW-1:0]    r_odata;
    logic [DW-1:0]    r_table [TABLE_SIZE];
    logic [DW-1:0]    r_rdata;

    logic             accept;
    logic             want_seed;
    logic [DW-1:0]    seed_init;
    logic             out_free;
    logic             draw_done;
    logic             seed_last;
    logic             mul_start;
    logic             rd_en;
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    logic             idx_load;
    logic [DW-1:0]    idx_value;
    logic             idx_valid;
    logic [IDX_W-1:0] idx;
    logic [DW-1:0]    lcg_next;

    slcg_lcg_step u_step (
        .i_clk   (i_clk),
        .i_start (mul_start),
        .i_state (r_lcg),
        .o_next  (lcg_next)
    );

    slcg_index #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (idx_load),
        .i_value (idx_value),
        .o_valid (idx_valid),
        .o_idx   (idx)
    );

    always_comb begin
        s_axis_tready = (r_state == S_IDLE) && idx_valid;
        accept        = s_axis_tvalid && s_axis_tready;
        want_seed     = s_axis_tdata[0] || !r_seeded;
        seed_init     = ((r_seed == '0) || (&r_seed)) ? DW'(1) : r_seed;
        out_free      = !r_ovalid || m_axis_tready;
        draw_done     = (r_state == S_DRAW) && out_free;
        seed_last     = (r_state == S_SEED_RED) && (r_cnt == '0);
        rd_en         = (accept && !want_seed) || ((r_state == S_IDX_WAIT) && idx_valid);
        mul_start     = rd_en || (r_state == S_SEED_MUL);
        // warm-up steps above the table size only advance the generator
        tbl_we        = ((r_state == S_SEED_RED) && (r_cnt < CNT_W'(TABLE_SIZE))) || draw_done;
        tbl_waddr     = draw_done ? idx : r_cnt[IDX_W-1:0];
        idx_load      = seed_last || draw_done;
        idx_value     = draw_done ? r_rdata : lcg_next;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = want_seed ? S_SEED_MUL : S_DRAW;
                end
            end
            S_SEED_MUL: begin
                n_state = S_SEED_RED;
            end
            S_SEED_RED: begin
                n_state = (r_cnt == '0) ? S_IDX_WAIT : S_SEED_MUL;
            end
            S_IDX_WAIT: begin
                if (idx_valid) begin
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seed   <= DW'(1);
            r_seeded <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (seed_last) begin
                r_seeded <= 1'b1;
            end
            if (draw_done) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && want_seed) begin
            r_lcg <= seed_init;
            r_cnt <= CNT_W'(TABLE_SIZE + slcg_pkg::WARMUP_EXTRA);
        end else begin
            if ((r_state == S_SEED_RED) || draw_done) begin
                r_lcg <= lcg_next;
            end
            if ((r_state == S_SEED_RED) && (r_cnt != '0)) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
        if (draw_done) begin
            r_odata <= r_rdata;
        end
    end

    // shuffle table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_waddr] <= (draw_done ? lcg_next : lcg_next);
        end
        if (rd_en) begin
            r_rdata <= r_table[idx];
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_odata};

    a_seed_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && want_seed) |=> (r_state == S_SEED_MUL))
        else $error("seeding request did not start warm-up");

    a_out_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_odata != '0))
        else $error("zero deviate delivered");

    a_out_from_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_DRAW))
        else $error("result appeared outside a draw");

    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seeded && (r_state == S_IDLE)) |-> (r_lcg != '0))
        else $error("generator state stuck at zero");

endmodule

@@ design/slcg_lcg_step.sv @@
// one Lehmer step: registered product by 16807, then folding modulo 2^31-1
module slcg_lcg_step (
    input  logic                          i_clk,
    input  logic                          i_start,
    input  logic [slcg_pkg::DATA_W-1:0]   i_state,
    output logic [slcg_pkg::DATA_W-1:0]   o_next
);

    logic [45:0] r_prod;
    logic [31:0] sum;
    logic [31:0] folded;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= 46'(i_state) * 46'(slcg_pkg::LCG_MULT);
        end
    end

    // 2^31 == 1 mod (2^31-1): add the high part onto the low part once
    always_comb begin
        sum    = 32'(r_prod[30:0]) + 32'(r_prod[45:31]);
        folded = (sum >= slcg_pkg::LCG_MOD) ? (sum - slcg_pkg::LCG_MOD) : sum;
        o_next = folded[slcg_pkg::DATA_W-1:0];
    end

endmodule

@@ design/slcg_index.sv @@
// shuffle table index: value / NDIV, saturated to the last entry
module slcg_index #(
    parameter int TABLE_SIZE = slcg_pkg::DEF_TABLE_SIZE
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_load,
    input  logic [slcg_pkg::DATA_W-1:0]                   i_value,
    output logic                                          o_valid,
    output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] o_idx
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [31:0] NDIV = 32'd1 + (slcg_pkg::LCG_MOD - 32'd1) / 32'(TABLE_SIZE);
    localparam bit POW2 = ((NDIV & (NDIV - 32'd1)) == 32'd0);
    localparam int SH = $clog2(NDIV);
    localparam logic [1:0] LAT = POW2 ? 2'd0 : 2'd2;

    function automatic logic [IDX_W-1:0] f_sat(input logic [31:0] q);
        logic [IDX_W-1:0] res;
        if (q >= 32'(TABLE_SIZE)) begin
            res = IDX_W'(TABLE_SIZE - 1);
        end else begin
            res = q[IDX_W-1:0];
        end
        return res;
    endfunction

    logic [1:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else if (i_load) begin
            r_pend <= LAT;
        end else if (r_pend != 2'd0) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    assign o_valid = (r_pend == 2'd0);

    generate
        if (POW2) begin : g_shift
            logic [IDX_W-1:0] r_idx;

            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_idx <= f_sat(32'(i_value >> SH));
                end
            end

            assign o_idx = r_idx;
        end else begin : g_recip
            // reciprocal estimate is low by at most one, fixed by one compare
            localparam logic [63:0] RECIP64 = (64'd1 << 40) / 64'(NDIV);
            localparam logic [17:0] RECIP = RECIP64[17:0];

            logic [slcg_pkg::DATA_W-1:0] r_x;
            logic [8:0]                  r_est;
            logic [IDX_W-1:0]            r_idx;
            logic [48:0]                 est_prod;
            logic [40:0]                 back_prod;
            logic [40:0]                 rem;
            logic [9:0]                  q_fix;

            always_comb begin
                est_prod  = 49'(r_x) * 49'(RECIP);
                back_prod = 41'(r_est) * 41'(NDIV);
                rem       = 41'(r_x) - back_prod;
                q_fix     = (rem >= 41'(NDIV)) ? (10'(r_est) + 10'd1) : 10'(r_est);
            end

            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_x <= i_value;
                end
                r_est <= est_prod[48:40];
                r_idx <= f_sat(32'(q_fix));
            end

            assign o_idx = r_idx;
        end
    endgenerate

endmodule
